// ----- sv/gsff_pkg.sv -----
// Shared constants, operation codes and transaction types of the grid slot table.
package gsff_pkg;

  localparam int ROWS   = 8;
  localparam int COLS   = 8;
  localparam int NSLOTS = ROWS * COLS;
  localparam int IDX_W  = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int PTR_W  = $clog2(NSLOTS + 1);

  localparam int KIND_W   = 2;
  localparam int ROW_W    = 3;
  localparam int COL_W    = 3;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LOCATE = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              use_first_free;
    logic [ROW_W-1:0]  slot_row;
    logic [COL_W-1:0]  slot_col;
    logic [ID_W-1:0]   item_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     item_out;
    logic [ROW_W-1:0]    found_row;
    logic [COL_W-1:0]    found_col;
    logic                grid_full;
  } rsp_t;

endpackage

// ----- sv/grid_slot_table_first_free_unit.sv -----
// Grid slot table with a first-free pointer: store, remove, read and locate.
//
//   channel | signals                              | direction | carries
//   --------+--------------------------------------+-----------+-----------------------
//   in      | in_valid_i, in_ready_o, in_data_i    | into unit | one operation (req_t)
//   out     | out_valid_o, out_ready_i, out_data_o | out       | one result (rsp_t)
//
// Sequencing: one operation at a time. Store, remove and read pass through slot read,
//   execute and result load from acceptance to a valid result. A store that
//   fills the first free slot then scans onward slot by slot for the next
//   empty one, up to NSLOTS. Locate reads one slot per cycle through the slot
//   memory's single read port, then does the result load.
// Reset: per-slot occupancy bits clear at once; no clearing pass over the memory.
// Stalls: a new transaction is taken while a result waits in the output register;
//   a second result holds in its final state until that register drains.
module grid_slot_table_first_free_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gsff_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gsff_pkg::rsp_t out_data_o
);
  import gsff_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ADV,
    S_LOC,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  rsp_t              res_q, res_d;
  rsp_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [PTR_W-1:0]  idx_q, idx_d;
  logic              range_q, range_d;
  logic [PTR_W-1:0]  free_q, free_d;
  logic [NSLOTS-1:0] valid_q, valid_d;
  logic [PTR_W-1:0]  scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pend_idx_q, pend_idx_d;

  // Slot memory: nonzero identifiers only; a clear valid bit means an empty slot.
  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  logic [ID_W-1:0]  ram_rdata;

  logic             in_accept;
  logic             in_range;
  logic [IDX_W-1:0] in_idx;
  logic             slot_hit;
  logic [ID_W-1:0]  slot_item;
  logic             loc_match;

  gsff_ram #(
    .WIDTH (ID_W),
    .DEPTH (NSLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[IDX_W-1:0]),
    .wdata_i (req_q.item_id),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Address decode of the incoming transaction: either coordinate out of range flags it.
  assign in_range = (32'(in_data_i.slot_row) < ROWS) && (32'(in_data_i.slot_col) < COLS);
  assign in_idx   = in_range ?
                    IDX_W'(32'(in_data_i.slot_row) * COLS + 32'(in_data_i.slot_col)) : '0;

  // Read the addressed slot on acceptance; sweep the table during locate.
  assign ram_raddr = (state_q == S_LOC) ? scan_q[IDX_W-1:0] : in_idx;

  assign slot_hit  = valid_q[idx_q[IDX_W-1:0]];
  assign slot_item = slot_hit ? ram_rdata : '0;

  // An empty slot matches only the zero identifier.
  assign loc_match = valid_q[pend_idx_q] ? (ram_rdata == req_q.item_id)
                                         : (req_q.item_id == '0);

  assign ram_we = (state_q == S_EXEC) && (req_q.kind == KIND_STORE) && range_q &&
                  (req_q.item_id != '0);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    range_d     = range_q;
    free_d      = free_q;
    valid_d     = valid_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;

    // Drain the output register when the consumer takes the transaction.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_d = in_data_i;
          res_d = '0;
          if ((in_data_i.kind == KIND_STORE) && in_data_i.use_first_free) begin
            idx_d   = free_q;
            range_d = (32'(free_q) < NSLOTS);
          end else begin
            idx_d   = PTR_W'(in_idx);
            range_d = in_range;
          end
          if (in_data_i.kind == KIND_LOCATE) begin
            scan_d  = '0;
            pend_d  = 1'b0;
            state_d = S_LOC;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        state_d = S_DONE;
        if (!range_q) begin
          res_d.status = STATUS_RANGE;
        end else if (req_q.kind == KIND_STORE) begin
          res_d.item_out  = req_q.item_id;
          res_d.found_row = ROW_W'(idx_q / COLS);
          res_d.found_col = COL_W'(idx_q % COLS);
          valid_d[idx_q[IDX_W-1:0]] = (req_q.item_id != '0);
          if ((req_q.item_id != '0) && (idx_q == free_q)) begin
            // Filled the first free slot: search onward for the next empty one.
            scan_d  = free_q + PTR_W'(1);
            state_d = S_ADV;
          end else if ((req_q.item_id == '0) && (idx_q < free_q)) begin
            free_d = idx_q;
          end
        end else begin
          res_d.item_out = slot_item;
          if (req_q.kind == KIND_REMOVE) begin
            valid_d[idx_q[IDX_W-1:0]] = 1'b0;
            if (idx_q < free_q) begin
              free_d = idx_q;
            end
          end
        end
      end

      S_ADV: begin
        if ((32'(scan_q) >= NSLOTS) || !valid_q[scan_q[IDX_W-1:0]]) begin
          free_d  = scan_q;
          state_d = S_DONE;
        end else begin
          scan_d = scan_q + PTR_W'(1);
        end
      end

      S_LOC: begin
        if (pend_q && loc_match) begin
          res_d.item_out  = req_q.item_id;
          res_d.found_row = ROW_W'(pend_idx_q / COLS);
          res_d.found_col = COL_W'(pend_idx_q % COLS);
          state_d         = S_DONE;
        end else if (32'(scan_q) < NSLOTS) begin
          // Issue the next slot read; its data is checked in the next cycle.
          pend_d     = 1'b1;
          pend_idx_d = scan_q[IDX_W-1:0];
          scan_d     = scan_q + PTR_W'(1);
        end else begin
          res_d.status = STATUS_NOT_FOUND;
          state_d      = S_DONE;
        end
      end

      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d           = res_q;
          out_d.grid_full = (32'(free_q) >= NSLOTS);
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      range_q     <= 1'b0;
      free_q      <= '0;
      valid_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      range_q     <= range_d;
      free_q      <= free_d;
      valid_q     <= valid_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
    end
  end

  // The free pointer never runs past the full mark.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_q) <= NSLOTS)
    else $error("free pointer beyond full mark");

  // Between transactions the slot under the free pointer is empty.
  a_free_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && (32'(free_q) < NSLOTS) |-> !valid_q[free_q[IDX_W-1:0]])
    else $error("free pointer marks an occupied slot");

  // Slot memory writes happen only while executing a store.
  a_write_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_EXEC) && (req_q.kind == KIND_STORE))
    else $error("slot write outside store execution");

  // A finished result lands in the output register once it is free.
  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (!out_valid_q || out_ready_i) |=> out_valid_q && in_ready_o)
    else $error("result not loaded");

endmodule

// ----- sv/gsff_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gsff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/grid_slot_table_first_free_unit_test.sv -----
// Self-checking testbench for the grid slot table with first-free pointer.
`timescale 1ns / 100ps

module grid_slot_table_first_free_unit_test;
  import gsff_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int PHASE_ITEMS  = 100;
  // Length of the one long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 3000;
  // Settling wait after the drain, sized for a locate or pointer scan over all slots.
  localparam int DRAIN_CYCLES = NSLOTS + 16;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {
    PHASE_FILL,
    PHASE_BLEND,
    PHASE_DRAIN
  } phase_e;

  // Track the slot grid and the first-free pointer, predict one response per
  // accepted request, and compare responses in order.
  class slot_table_scoreboard;
    logic [ID_W-1:0] slot_ids [NSLOTS];
    int              free_idx;
    rsp_t            pending_responses [$];
    int              fault_count;
    int              result_index;

    function new();
      foreach (slot_ids[i]) slot_ids[i] = '0;
      free_idx     = 0;
      fault_count  = 0;
      result_index = 0;
    endfunction

    function rsp_t apply_operation(req_t op);
      rsp_t r;
      int   idx;
      int   at_ptr;
      int   i;
      bit   in_range;
      r        = '0;
      in_range = (op.slot_row < ROWS) && (op.slot_col < COLS);
      idx      = in_range ? op.slot_row * COLS + op.slot_col : 0;
      case (op.kind)
        KIND_STORE: begin
          if (op.use_first_free) begin
            idx      = free_idx;
            in_range = idx < NSLOTS;
          end
          if (!in_range) begin
            r.status = STATUS_RANGE;
          end else begin
            at_ptr        = free_idx;
            slot_ids[idx] = op.item_id;
            // Filling the free slot walks the pointer to the next hole;
            // emptying an earlier slot pulls it back.
            if (op.item_id != '0 && idx == at_ptr) begin
              while (free_idx < NSLOTS && slot_ids[free_idx] != '0) free_idx++;
            end else if (op.item_id == '0 && idx < at_ptr) begin
              free_idx = idx;
            end
            r.item_out  = op.item_id;
            r.found_row = ROW_W'(idx / COLS);
            r.found_col = COL_W'(idx % COLS);
          end
        end
        KIND_REMOVE, KIND_READ: begin
          if (!in_range) begin
            r.status = STATUS_RANGE;
          end else begin
            r.item_out = slot_ids[idx];
            if (op.kind == KIND_REMOVE) begin
              slot_ids[idx] = '0;
              if (idx < free_idx) free_idx = idx;
            end
          end
        end
        default: begin
          i = 0;
          while (i < NSLOTS && slot_ids[i] != op.item_id) i++;
          if (i < NSLOTS) begin
            r.item_out  = op.item_id;
            r.found_row = ROW_W'(i / COLS);
            r.found_col = COL_W'(i % COLS);
          end else begin
            r.status = STATUS_NOT_FOUND;
          end
        end
      endcase
      r.grid_full = (free_idx >= NSLOTS);
      return r;
    endfunction

    function void note_request(req_t op);
      pending_responses.push_back(apply_operation(op));
    endfunction

    function void log_mismatch(string what);
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("%0t: response %0d: %s", $time, result_index, what);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_responses.size() == 0) begin
        log_mismatch($sformatf("unexpected response %h", got));
        result_index++;
        return;
      end
      want = pending_responses.pop_front();
      if (got.status != want.status)
        log_mismatch($sformatf("status exp %0d got %0d", want.status, got.status));
      if (got.item_out != want.item_out)
        log_mismatch($sformatf("item_out exp %h got %h", want.item_out, got.item_out));
      if (got.found_row != want.found_row)
        log_mismatch($sformatf("found_row exp %0d got %0d", want.found_row, got.found_row));
      if (got.found_col != want.found_col)
        log_mismatch($sformatf("found_col exp %0d got %0d", want.found_col, got.found_col));
      if (got.grid_full != want.grid_full)
        log_mismatch($sformatf("grid_full exp %0d got %0d", want.grid_full, got.grid_full));
      result_index++;
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  req_t in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  rsp_t out_data;

  slot_table_scoreboard sb = new();
  int results_seen = 0;

  grid_slot_table_first_free_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every response transaction at the rising edge it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
      results_seen++;
    end
  end

  function automatic req_t make_op(logic [KIND_W-1:0] kind, logic ff,
                                   int row, int col, logic [ID_W-1:0] id);
    req_t op;
    op.kind           = kind;
    op.use_first_free = ff;
    op.slot_row       = ROW_W'(row);
    op.slot_col       = COL_W'(col);
    op.item_id        = id;
    return op;
  endfunction

  // Mix small identifiers (so locates hit), full-width noise, the extremes,
  // and identifiers already sitting in the grid.
  function automatic logic [ID_W-1:0] pick_item_id();
    int sel = $urandom_range(0, 9);
    if (sel < 4) return ID_W'($urandom_range(1, 24));
    if (sel < 7) return ID_W'($urandom);
    if (sel == 7) return '0;
    if (sel == 8) return '1;
    return sb.slot_ids[$urandom_range(0, NSLOTS - 1)];
  endfunction

  // Offer one request from a falling edge and hold it until it is taken.
  // Leave valid high on return so a following request in the burst goes
  // out without a bubble.
  task automatic send_op(input req_t op);
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op);
    @(negedge clk);
  endtask

  // Drop valid and idle the sender for a number of cycles.
  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Receiver: random ready patterns in segments, plus one long hold-off once
  // traffic is flowing, so the unit fills its output stage and stalls input.
  initial begin : receiver
    int  mode;
    int  span;
    bit  held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= (k % 4 == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Abort when no transaction moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("[grid_slot_table_first_free_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    req_t   directed_ops [$];
    req_t   op;
    phase_e phase;
    int     burst_left;
    int     total;
    int     sel;

    // Directed: empty grid, pointer moves both ways, id extremes, corner slots.
    directed_ops.push_back(make_op(KIND_READ,   1'b0, 0, 0, '0));
    directed_ops.push_back(make_op(KIND_LOCATE, 1'b0, 0, 0, '0));
    directed_ops.push_back(make_op(KIND_LOCATE, 1'b1, 7, 7, 16'h1234));
    directed_ops.push_back(make_op(KIND_STORE,  1'b1, 7, 7, 16'hFFFF));
    directed_ops.push_back(make_op(KIND_STORE,  1'b0, 7, 7, 16'h0001));
    directed_ops.push_back(make_op(KIND_STORE,  1'b0, 0, 1, 16'h8000));
    directed_ops.push_back(make_op(KIND_STORE,  1'b1, 3, 5, 16'h5555));
    directed_ops.push_back(make_op(KIND_LOCATE, 1'b0, 0, 0, 16'hFFFF));
    directed_ops.push_back(make_op(KIND_LOCATE, 1'b1, 0, 0, 16'h0001));
    directed_ops.push_back(make_op(KIND_READ,   1'b1, 7, 7, '0));
    directed_ops.push_back(make_op(KIND_REMOVE, 1'b0, 0, 1, '0));
    directed_ops.push_back(make_op(KIND_REMOVE, 1'b1, 3, 4, 16'hABCD));
    directed_ops.push_back(make_op(KIND_STORE,  1'b0, 0, 0, '0));
    directed_ops.push_back(make_op(KIND_STORE,  1'b1, 0, 0, 16'hAAAA));
    directed_ops.push_back(make_op(KIND_STORE,  1'b1, 0, 0, '0));
    directed_ops.push_back(make_op(KIND_STORE,  1'b0, 7, 0, 16'h2A2A));
    directed_ops.push_back(make_op(KIND_STORE,  1'b0, 0, 7, 16'h7FFF));
    directed_ops.push_back(make_op(KIND_LOCATE, 1'b0, 0, 0, '0));
    directed_ops.push_back(make_op(KIND_REMOVE, 1'b0, 7, 7, '0));
    directed_ops.push_back(make_op(KIND_READ,   1'b0, 7, 7, '0));
    directed_ops.push_back(make_op(KIND_LOCATE, 1'b0, 0, 0, 16'h0001));

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    total      = directed_ops.size() + RANDOM_ITEMS;
    burst_left = 0;
    for (int n = 0; n < total; n++) begin
      // Start a new burst; most bursts follow a gap, some run straight on.
      if (burst_left == 0) begin
        if (n > 0 && $urandom_range(0, 3) != 0)
          idle_sender(($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6));
        burst_left = $urandom_range(1, 30);
      end

      if (n < directed_ops.size()) begin
        op = directed_ops[n];
      end else begin
        // Cycle fill, blend and drain phases so the grid runs full and empty.
        case (((n - directed_ops.size()) / PHASE_ITEMS) % 3)
          0:       phase = PHASE_FILL;
          1:       phase = PHASE_BLEND;
          default: phase = PHASE_DRAIN;
        endcase
        sel               = $urandom_range(0, 99);
        op.kind           = KIND_READ;
        op.use_first_free = 1'($urandom_range(0, 1));
        op.slot_row       = ROW_W'($urandom_range(0, ROWS - 1));
        op.slot_col       = COL_W'($urandom_range(0, COLS - 1));
        op.item_id        = pick_item_id();
        case (phase)
          PHASE_FILL: begin
            if (sel < 78) begin
              op.kind           = KIND_STORE;
              op.use_first_free = 1'b1;
              if (op.item_id == '0) op.item_id = ID_W'($urandom_range(1, 65535));
            end else if (sel < 88) begin
              op.kind           = KIND_STORE;
              op.use_first_free = 1'b0;
            end else if (sel < 95) begin
              op.kind = KIND_LOCATE;
            end else begin
              op.kind = KIND_REMOVE;
            end
          end
          PHASE_DRAIN: begin
            if (sel < 50) begin
              op.kind = KIND_REMOVE;
            end else if (sel < 62) begin
              op.kind           = KIND_STORE;
              op.use_first_free = 1'b0;
              op.item_id        = '0;
            end else if (sel < 75) begin
              op.kind = KIND_READ;
            end else if (sel < 88) begin
              op.kind = KIND_LOCATE;
            end else begin
              op.kind = KIND_STORE;
            end
          end
          default: begin
            if (sel < 30)      op.kind = KIND_STORE;
            else if (sel < 55) op.kind = KIND_REMOVE;
            else if (sel < 75) op.kind = KIND_READ;
            else               op.kind = KIND_LOCATE;
          end
        endcase
      end

      send_op(op);
      burst_left--;
    end

    // Drain: drop valid, wait out every pending response, then let the unit
    // settle long enough for any stray response to show up.
    in_valid <= 1'b0;
    while (sb.pending_responses.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.fault_count == 0 && sb.pending_responses.size() == 0) begin
      $display("[grid_slot_table_first_free_unit] OK");
    end else begin
      $display("[grid_slot_table_first_free_unit] ERROR");
    end
    $finish;
  end

endmodule
